/* rtl/band_threshold_run_encoder_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the band threshold run encoder
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BAND_THRESHOLD_RUN_ENCODER_UNIT_ASSERT_SVH
`define BAND_THRESHOLD_RUN_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTH
// property holds whenever the antecedent holds, same cycle
`define BTRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btre assertion failed");
// consequence must hold in the cycle after the antecedent
`define BTRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btre assertion failed");
`else
`define BTRE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BTRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/btre_pkg.sv */
// ---------------------------------------------------------------------------
// btre_pkg
// Widths, register codes and shared types of the band threshold run encoder.
// ---------------------------------------------------------------------------
package btre_pkg;

  localparam int PIXEL_W     = 8;
  localparam int LEN_W       = 13;
  localparam int COL_W       = 12;
  localparam int ROW_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int MAX_COLUMNS = 4096;

  localparam logic [PIXEL_W-1:0] LOW_LEVEL_RST  = 8'd128;
  localparam logic [PIXEL_W-1:0] HIGH_LEVEL_RST = 8'd255;
  localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = 13'd640;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LEVEL  = 2'd0,
    CFG_HIGH_LEVEL = 2'd1,
    CFG_ROW_LENGTH = 2'd2
  } cfg_idx_e;

  // settings as the datapath sees them
  typedef struct packed {
    logic [PIXEL_W-1:0] low_level;
    logic [PIXEL_W-1:0] high_level;
    logic [COL_W-1:0]   last_col;
  } cfg_t;

  // one classified pixel sitting in the input register
  typedef struct packed {
    logic valid;
    logic fg;
    logic frame_start;
  } stage_t;

endpackage

/* rtl/btre_pix_if.sv */
// ---------------------------------------------------------------------------
// btre_pix_if
// Pixel stream channel: one gray pixel and its frame start flag per word.
// ---------------------------------------------------------------------------
interface btre_pix_if;
  import btre_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

/* rtl/btre_run_if.sv */
// ---------------------------------------------------------------------------
// btre_run_if
// Run channel: row, first and last column of one finished run per word.
// ---------------------------------------------------------------------------
interface btre_run_if;
  import btre_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] run_row;
  logic [COL_W-1:0] run_first;
  logic [COL_W-1:0] run_last;

  modport source (output valid, run_row, run_first, run_last, input ready);
  modport sink   (input valid, run_row, run_first, run_last, output ready);
endinterface

/* rtl/btre_cfg_if.sv */
// ---------------------------------------------------------------------------
// btre_cfg_if
// Configuration write channel: register index and write data per word.
// ---------------------------------------------------------------------------
interface btre_cfg_if;
  import btre_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/btre_cfg_regs.sv */
// ---------------------------------------------------------------------------
// btre_cfg_regs
// Level and row length registers; derives the clamped last column.
// ---------------------------------------------------------------------------
module btre_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [btre_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [btre_pkg::CFG_DATA_W-1:0] wr_data_i,
  output btre_pkg::cfg_t                 cfg_o
);
  import btre_pkg::*;

  logic [PIXEL_W-1:0] low_level_q;
  logic [PIXEL_W-1:0] high_level_q;
  logic [LEN_W-1:0]   row_length_q;
  logic [LEN_W-1:0]   len_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_level_q  <= LOW_LEVEL_RST;
      high_level_q <= HIGH_LEVEL_RST;
      row_length_q <= ROW_LENGTH_RST;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_LOW_LEVEL:  low_level_q  <= wr_data_i[PIXEL_W-1:0];
        CFG_HIGH_LEVEL: high_level_q <= wr_data_i[PIXEL_W-1:0];
        CFG_ROW_LENGTH: row_length_q <= wr_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above MAX_COLUMNS saturates
  always_comb begin
    len_m1 = row_length_q - LEN_W'(1);
    if (row_length_q == '0) begin
      len_m1 = '0;
    end else if (row_length_q > LEN_W'(MAX_COLUMNS)) begin
      len_m1 = LEN_W'(MAX_COLUMNS - 1);
    end
  end

  assign cfg_o.low_level  = low_level_q;
  assign cfg_o.high_level = high_level_q;
  assign cfg_o.last_col   = len_m1[COL_W-1:0];
endmodule

/* rtl/btre_in_stage.sv */
// ---------------------------------------------------------------------------
// btre_in_stage
// Input register: classifies the pixel against the band on the way in.
// ---------------------------------------------------------------------------
module btre_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  btre_pkg::cfg_t              cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [btre_pkg::PIXEL_W-1:0] pixel_i,
  input  logic                        frame_start_i,
  input  logic                        advance_i,
  output btre_pkg::stage_t            stage_o
);
  import btre_pkg::*;

  logic valid_q;
  logic fg_q;
  logic frame_q;
  logic fg_d;

  // stage frees up when empty or when the core takes its word this cycle
  assign ready_o = !valid_q || advance_i;

  assign fg_d = (pixel_i >= cfg_i.low_level) && (pixel_i <= cfg_i.high_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      fg_q    <= fg_d;
      frame_q <= frame_start_i;
    end
  end

  assign stage_o.valid       = valid_q;
  assign stage_o.fg          = fg_q;
  assign stage_o.frame_start = frame_q;
endmodule

/* rtl/btre_run_core.sv */
// ---------------------------------------------------------------------------
// btre_run_core
// Row/column counters, run tracking and the result register.
// ---------------------------------------------------------------------------
`include "band_threshold_run_encoder_unit_assert.svh"

module btre_run_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  btre_pkg::cfg_t            cfg_i,
  input  btre_pkg::stage_t          stage_i,
  output logic                      advance_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [btre_pkg::ROW_W-1:0] res_row_o,
  output logic [btre_pkg::COL_W-1:0] res_first_o,
  output logic [btre_pkg::COL_W-1:0] res_last_o
);
  import btre_pkg::*;

  logic             in_run_q, in_run_d;
  logic [COL_W-1:0] start_col_q, start_col_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             res_valid_q, res_valid_d;
  logic [ROW_W-1:0] res_row_q;
  logic [COL_W-1:0] res_first_q, res_last_q;

  logic             take;
  logic             run_cur;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             is_last;
  logic             emit;
  logic [COL_W-1:0] emit_first, emit_last;

  // result register drains or is empty
  assign advance_o = !res_valid_q || res_ready_i;
  assign take      = advance_o && stage_i.valid;

  always_comb begin
    // frame start restarts position and drops an open run
    run_cur = stage_i.frame_start ? 1'b0 : in_run_q;
    col_cur = stage_i.frame_start ? '0   : col_q;
    row_cur = stage_i.frame_start ? '0   : row_q;
    is_last = (col_cur >= cfg_i.last_col);

    in_run_d    = run_cur;
    start_col_d = start_col_q;
    emit        = 1'b0;
    emit_first  = col_cur;
    emit_last   = col_cur;

    if (!run_cur && stage_i.fg) begin
      start_col_d = col_cur;
      if (is_last) begin
        emit = 1'b1;            // run opens and closes on the row's last pixel
      end else begin
        in_run_d = 1'b1;
      end
    end else if (run_cur && !stage_i.fg) begin
      emit       = 1'b1;
      emit_first = start_col_q;
      emit_last  = col_cur - COL_W'(1);
      in_run_d   = 1'b0;
    end else if (run_cur && is_last) begin
      emit       = 1'b1;
      emit_first = start_col_q;
      in_run_d   = 1'b0;
    end

    if (is_last) begin
      col_d = '0;
      row_d = row_cur + ROW_W'(1);  // wraps after the last row
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end

    res_valid_d = stage_i.valid && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      start_col_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_run_q    <= in_run_d;
        start_col_q <= start_col_d;
        col_q       <= col_d;
        row_q       <= row_d;
      end
      if (advance_o) begin
        res_valid_q <= res_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_d) begin
      res_row_q   <= row_cur;
      res_first_q <= emit_first;
      res_last_q  <= emit_last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_row_o   = res_row_q;
  assign res_first_o = res_first_q;
  assign res_last_o  = res_last_q;

  // an open run always started at an earlier column
  `BTRE_ASSERT_IMPL(a_run_start_before_col, clk_i, rst_ni, in_run_q, start_col_q < col_q)
  // a reported run never runs backwards
  `BTRE_ASSERT_IMPL(a_run_ordered, clk_i, rst_ni, res_valid_q, res_first_q <= res_last_q)
  // the row's last pixel rewinds the column and leaves no run open
  `BTRE_ASSERT_NEXT(a_row_end_rewind, clk_i, rst_ni, take && is_last,
                    (col_q == '0) && !in_run_q)
endmodule

/* rtl/band_threshold_run_encoder_unit.sv */
// ---------------------------------------------------------------------------
// band_threshold_run_encoder_unit
// Band threshold run-length encoder for raster gray pixel streams.
// ---------------------------------------------------------------------------
// Takes one gray pixel per word in raster order and reports every maximal
// horizontal run of pixels with low_level <= pixel <= high_level as one word
// (row, first column, last column inclusive). A run closes at the first
// background pixel, whose word carries the run, or at the row's last pixel.
// A pixel word with frame_start set restarts row and column at zero and
// drops any open run unreported. row_length 0 acts as 1, values above 4096
// act as 4096; rows count modulo 4096. Throughput is one pixel per clock:
// while run_o is ready: an input register (band compare) feeds a result
// register (counters and run tracking), which registers the run word of the
// closing pixel. pix_i.ready follows run_o.ready combinationally when both
// registers are full. Config writes are always accepted (cfg_i.ready = 1)
// but must only be issued while no pixel is in flight.
// ---------------------------------------------------------------------------
`include "band_threshold_run_encoder_unit_assert.svh"

module band_threshold_run_encoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  btre_pix_if.sink     pix_i,
  btre_run_if.source   run_o,
  btre_cfg_if.sink     cfg_i
);
  import btre_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  btre_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // stage 1: capture and classify
  btre_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (pix_i.valid),
    .ready_o       (pix_i.ready),
    .pixel_i       (pix_i.pixel),
    .frame_start_i (pix_i.frame_start),
    .advance_i     (advance),
    .stage_o       (stage)
  );

  // stage 2: run tracking and result register
  btre_run_core u_run_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .advance_o   (advance),
    .res_valid_o (run_o.valid),
    .res_ready_i (run_o.ready),
    .res_row_o   (run_o.run_row),
    .res_first_o (run_o.run_first),
    .res_last_o  (run_o.run_last)
  );

  // a pending result blocks the pipe only while the sink holds off
  `BTRE_ASSERT_IMPL(a_stall_only_on_backpressure, clk_i, rst_ni,
                    !pix_i.ready, stage.valid && run_o.valid && !run_o.ready)
  // a result word always comes from a pixel held in the input register
  `BTRE_ASSERT_NEXT(a_result_has_source, clk_i, rst_ni,
                    !stage.valid && !run_o.valid, !run_o.valid)
endmodule

/* sim/band_threshold_run_encoder_unit_tb.sv */
// ---------------------------------------------------------------------------
// band_threshold_run_encoder_unit_tb
// Self-checking bench for the band threshold run encoder. Pixel words go in
// through the pixel channel. A behavioral tracker of rows, columns and open
// runs predicts every run word. Run words coming out are compared in order,
// field by field. Directed tests cover band edges, row ends, frame restarts,
// single-column rows and clamped row lengths. Random phases follow, with
// random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module band_threshold_run_encoder_unit_tb;
  import btre_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DRAIN_CYCLES     = 12;    // two-stage pipe plus worst sink stall
  localparam int RANDOM_WORDS     = 750;
  localparam int QUIET_WORDS      = 150;   // tail of the random part, no idling
  localparam int SINGLE_COL_WORDS = 60;
  localparam int WIDE_WORDS       = 20;

  typedef struct packed {
    logic [ROW_W-1:0] run_row;
    logic [COL_W-1:0] run_first;
    logic [COL_W-1:0] run_last;
  } run_word_t;

  logic clk_i;
  logic rst_ni;

  btre_pix_if pix_ch ();
  btre_run_if run_ch ();
  btre_cfg_if cfg_ch ();

  band_threshold_run_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_ch),
    .run_o  (run_ch),
    .cfg_i  (cfg_ch)
  );

  // tracker copy of the block's settings and state
  logic [PIXEL_W-1:0] band_low;
  logic [PIXEL_W-1:0] band_high;
  logic [LEN_W-1:0]   row_len;
  bit                 run_open;
  logic [COL_W-1:0]   run_start;
  logic [COL_W-1:0]   next_col;
  logic [ROW_W-1:0]   next_row;

  run_word_t pending_runs[$];   // predicted run words, oldest first
  int        error_cnt;
  int        cycle_cnt;
  bit        idle_on;           // random gaps and stalls enabled

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Run tracker: mirrors the block for one accepted pixel word and queues
  // the run word it closes, if any.
  // -------------------------------------------------------------------------
  task automatic encode_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
    int unsigned span;
    logic [COL_W-1:0] col;
    bit at_end;
    bit fg;
    run_word_t w;
    // row length 0 behaves as 1, anything past 4096 as 4096
    span = (row_len == '0) ? 1 : ((row_len > MAX_COLUMNS) ? MAX_COLUMNS : row_len);
    if (fs) begin
      next_row = '0;
      next_col = '0;
      run_open = 1'b0;        // open run dropped, no word
    end
    col    = next_col;
    // a shrunk row length can leave the column past the row end
    at_end = (col >= span - 1);
    fg     = (pix >= band_low) && (pix <= band_high);
    w.run_row = next_row;
    if (!run_open && fg) begin
      run_start = col;
      if (at_end) begin
        // run born on the row's last pixel: one-pixel run
        w.run_first = col;
        w.run_last  = col;
        pending_runs = {pending_runs, w};
      end else begin
        run_open = 1'b1;
      end
    end else if (run_open && !fg) begin
      w.run_first = run_start;
      w.run_last  = col - 1'b1;
      pending_runs = {pending_runs, w};
      run_open = 1'b0;
    end else if (run_open && at_end) begin
      w.run_first = run_start;
      w.run_last  = col;
      pending_runs = {pending_runs, w};
      run_open = 1'b0;
    end
    if (at_end) begin
      next_col = '0;
      next_row = next_row + 1'b1;   // 12-bit counter wraps after row 4095
    end else begin
      next_col = col + 1'b1;
    end
  endtask

  // -------------------------------------------------------------------------
  // Pixel source: optional gap burst, then hold the word until accepted.
  // valid stays high after acceptance so back-to-back words need no toggle.
  // -------------------------------------------------------------------------
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= fs;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    encode_pixel(pix, fs);
  endtask

  // stop sending and let every predicted run word come out
  task automatic drain_runs();
    pix_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    // pixels that close no run may still sit in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one config word; valid is left high for the next write
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_LOW_LEVEL: begin
        band_low = data[PIXEL_W-1:0];
      end
      CFG_HIGH_LEVEL: begin
        band_high = data[PIXEL_W-1:0];
      end
      CFG_ROW_LENGTH: begin
        row_len = data[LEN_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // all registers, written only once the block is idle
  task automatic apply_config(input int unsigned lo, input int unsigned hi,
                              input int unsigned len);
    drain_runs();
    write_reg(CFG_LOW_LEVEL, CFG_DATA_W'(lo));
    write_reg(CFG_HIGH_LEVEL, CFG_DATA_W'(hi));
    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len));
    cfg_ch.valid <= 1'b0;
  endtask

  // gray value inside or outside the current band
  function automatic logic [PIXEL_W-1:0] pick_pixel(input bit want_fg);
    if (want_fg && band_low <= band_high)
      return PIXEL_W'($urandom_range(band_low, band_high));
    if (band_low > 0 && (band_high == 8'hFF || $urandom_range(0, 1) == 0))
      return PIXEL_W'($urandom_range(0, band_low - 1));
    if (band_high < 8'hFF)
      return PIXEL_W'($urandom_range(band_high + 1, 255));
    return PIXEL_W'($urandom_range(0, 255));
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // reset settings: band 128..255, 640-pixel rows
  task automatic test_reset_settings();
    send_pixel(8'd127, 1'b1);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd127, 1'b0);   // closes run 1..2 on row 0
    send_pixel(8'd0,   1'b0);
  endtask

  // band edges, row-end close, last-pixel start, frame restart mid-run
  task automatic test_band_edges();
    apply_config(10, 200, 8);
    send_pixel(8'd10,  1'b1);   // low edge, column 0
    send_pixel(8'd200, 1'b0);   // high edge
    send_pixel(8'd201, 1'b0);   // just above: closes 0..1
    send_pixel(8'd9,   1'b0);   // just below
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd100, 1'b0);   // row end closes 6..7
    repeat (7) send_pixel(8'd0, 1'b0);
    send_pixel(8'd150, 1'b0);   // starts on last column: one-pixel run
    send_pixel(8'd50,  1'b0);
    send_pixel(8'd50,  1'b0);   // open run on row 2
    send_pixel(8'd0,   1'b1);   // frame restart drops it
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd255, 1'b0);   // closes 1..1 on row 0
  endtask

  // low above high: nothing is foreground; then a one-value band
  task automatic test_empty_band();
    apply_config(200, 100, 4);
    send_pixel(8'd100, 1'b1);
    send_pixel(8'd150, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd201, 1'b0);
    send_pixel(8'd99,  1'b0);
    send_pixel(8'd128, 1'b0);
    apply_config(77, 77, 4);
    send_pixel(8'd76, 1'b1);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd78, 1'b0);
    send_pixel(8'd77, 1'b0);    // last column
  endtask

  // row length 0 acts as 1: each pixel is its own row
  task automatic test_single_column_rows();
    apply_config(0, 254, 0);
    send_pixel(8'd255, 1'b1);
    for (int i = 1; i < SINGLE_COL_WORDS; i++)
      send_pixel(($urandom_range(0, 7) == 0) ? 8'd255 : 8'(i), 1'b0);
  endtask

  // oversized row lengths clamp to 4096 columns: no row end early in the row
  task automatic test_wide_rows();
    apply_config(64, 191, 4097);
    send_pixel(8'd100, 1'b1);
    for (int c = 1; c < WIDE_WORDS; c++)
      send_pixel(PIXEL_W'($urandom_range(0, 255)), 1'b0);
    send_pixel(8'd0, 1'b0);
    apply_config(64, 191, 8191);
    send_pixel(8'd100, 1'b1);
    for (int c = 1; c < WIDE_WORDS; c++)
      send_pixel(PIXEL_W'($urandom_range(0, 255)), 1'b0);
    send_pixel(8'd0, 1'b0);
  endtask

  // row length shrinks while a run is open: next pixel ends the row
  task automatic test_row_shrink();
    apply_config(0, 127, 16);
    send_pixel(8'd200, 1'b1);
    repeat (7) send_pixel(8'd200, 1'b0);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd50, 1'b0);    // run open at columns 8..9
    apply_config(0, 127, 4);
    send_pixel(8'd50, 1'b0);    // column 10 past end: closes 8..10
    send_pixel(8'd50, 1'b0);
    apply_config(0, 127, 2);
    send_pixel(8'd255, 1'b0);   // background at column 1 closes 0..0
  endtask

  // random settings and runs; the tail runs without gaps or stalls
  task automatic test_random_frames();
    int  sent;
    int  phase_len;
    bit  want_fg;
    int unsigned lo, hi, len;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0: begin lo = 0; hi = 255; end
        1: begin lo = $urandom_range(1, 255); hi = $urandom_range(0, lo - 1); end
        default: begin
          lo = $urandom_range(0, 255);
          hi = $urandom_range(lo, 255);
        end
      endcase
      case ($urandom_range(0, 15))
        0:       len = 0;
        1:       len = $urandom_range(32, 300);
        default: len = $urandom_range(1, 24);
      endcase
      apply_config(lo, hi, len);
      if (sent >= RANDOM_WORDS - QUIET_WORDS)
        idle_on = 1'b0;
      phase_len = $urandom_range(40, 120);
      want_fg   = 1'($urandom_range(0, 1));
      for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++) begin
        if ($urandom_range(0, 3) == 0)
          want_fg = !want_fg;
        send_pixel(pick_pixel(want_fg),
                   (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 63) == 0));
        sent++;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Run sink: random stall bursts on ready
  // -------------------------------------------------------------------------
  initial begin : sink_stall
    int hold;
    hold = 0;
    run_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && idle_on && $urandom_range(0, 5) == 0)
        hold = $urandom_range(1, 5);
      if (hold > 0) begin
        run_ch.ready <= 1'b0;
        hold--;
      end else begin
        run_ch.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Run checker: every accepted run word against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_runs
    run_word_t want;
    if (rst_ni && run_ch.valid && run_ch.ready) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run word: row %0d, first %0d, last %0d",
               run_ch.run_row, run_ch.run_first, run_ch.run_last);
        error_cnt++;
      end else begin
        want = pending_runs.pop_front();
        if (run_ch.run_row !== want.run_row) begin
          $error("run_row mismatch: expected %0d, actual %0d",
                 want.run_row, run_ch.run_row);
          error_cnt++;
        end
        if (run_ch.run_first !== want.run_first) begin
          $error("run_first mismatch: expected %0d, actual %0d",
                 want.run_first, run_ch.run_first);
          error_cnt++;
        end
        if (run_ch.run_last !== want.run_last) begin
          $error("run_last mismatch: expected %0d, actual %0d",
                 want.run_last, run_ch.run_last);
          error_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    error_cnt = 0;
    cycle_cnt = 0;
    idle_on   = 1'b1;
    band_low  = LOW_LEVEL_RST;
    band_high = HIGH_LEVEL_RST;
    row_len   = ROW_LENGTH_RST;
    run_open  = 1'b0;
    run_start = '0;
    next_col  = '0;
    next_row  = '0;

    rst_ni             <= 1'b0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_LOW_LEVEL;
    cfg_ch.data        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_band_edges();
    test_empty_band();
    test_row_shrink();
    test_single_column_rows();
    test_wide_rows();
    test_random_frames();

    drain_runs();
    if (error_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
